// ----- sv/lcdn_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdn_pkg
// Shared types, command codes and constants for the character LCD nibble
// sequencer (4-bit controller mode behind an I2C port expander).
// ----------------------------------------------------------------------------
package lcdn_pkg;

    // Command codes of the input beat
    localparam logic [2:0] CMD_WRITE_CHAR = 3'd0;
    localparam logic [2:0] CMD_SET_CURSOR = 3'd1;
    localparam logic [2:0] CMD_DISP_CTRL  = 3'd2;
    localparam logic [2:0] CMD_CLEAR      = 3'd3;
    localparam logic [2:0] CMD_INIT       = 3'd4;
    localparam logic [2:0] CMD_SHUTDOWN   = 3'd5;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WAIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_WAIT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] PULSE_WAIT_RST   = 4'd1;
    localparam logic [CFG_DATA_W-1:0] COMMAND_WAIT_RST = 4'd4;

    // Field widths
    localparam int unsigned WAIT_W = 5;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 16;

    // Controller bytes
    localparam logic [7:0] LCD_CURSOR_ROW0 = 8'h80;
    localparam logic [7:0] LCD_CURSOR_ROW1 = 8'hC0;
    localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_DISP_OFF    = 8'h08;

    // Steps per controller byte, bytes per init run
    localparam logic [2:0] STEP_LAST = 3'd5;
    localparam logic [2:0] INIT_LAST = 3'd5;

    // Default job queue depth
    localparam int unsigned JOB_FIFO_DEPTH = 4;

    // One classified command waiting for the back end
    typedef struct packed {
        logic       init;     // run the six-byte init sequence
        logic       rejected; // bad cursor position, one empty result
        logic       clr;      // double settle time on the final nibble
        logic       rs;       // register select (character data)
        logic       bl;       // backlight bit for every byte
        logic [7:0] value;    // controller byte when not init
    } t_job;

    // Init sequence, one controller byte per index
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h80;
            3'd5:    b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- sv/lcdn_front.sv -----
// ----------------------------------------------------------------------------
// lcdn_front
// Accepts command beats, checks the cursor position, tracks the backlight
// state and pushes one classified job per known command into the queue.
// ----------------------------------------------------------------------------
module lcdn_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_char_code,
    input  logic [5:0]         i_column,
    input  logic [1:0]         i_row,
    input  logic               i_light,
    input  logic               i_cursor,
    input  logic               i_blink,
    input  logic               i_full,
    output logic               o_push,
    output lcdn_pkg::t_job     o_job
);
    import lcdn_pkg::*;

    logic r_bl;
    logic n_bl;
    logic known;
    logic accept;

    assign o_tready = !i_full;
    assign accept   = i_tvalid && o_tready;

    // Classify the command and work out the new backlight state
    always_comb begin
        known = 1'b1;
        n_bl  = r_bl;
        o_job = '0;
        case (i_command)
            CMD_WRITE_CHAR: begin
                o_job.value = i_char_code;
                o_job.rs    = 1'b1;
            end
            CMD_SET_CURSOR: begin
                if (i_column > 6'd15 || i_row > 2'd1) begin
                    o_job.rejected = 1'b1;
                end else begin
                    o_job.value = (i_row[0] ? LCD_CURSOR_ROW1 : LCD_CURSOR_ROW0)
                                  | {4'b0, i_column[3:0]};
                end
            end
            CMD_DISP_CTRL: begin
                n_bl        = i_light;
                o_job.value = LCD_DISP_ON | {6'b0, i_cursor, i_blink};
            end
            CMD_CLEAR: begin
                o_job.value = LCD_CLEAR;
                o_job.clr   = 1'b1;
            end
            CMD_INIT: begin
                n_bl       = 1'b1;
                o_job.init = 1'b1;
                o_job.clr  = 1'b1;
            end
            CMD_SHUTDOWN: begin
                n_bl        = 1'b0;
                o_job.value = LCD_DISP_OFF;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        o_job.bl = n_bl;
    end

    assign o_push = accept && known;

    // Hold backlight state, update on accepted commands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bl <= 1'b1;
        end else if (o_push) begin
            r_bl <= n_bl;
        end
    end

    // Push only when the queue has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("front pushed into a full queue");

    // Rejected jobs never carry a payload byte
    a_rej_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_job.rejected) |-> (o_job.value == 8'h00 && !o_job.init))
        else $error("rejected job carries a byte");

    // Shutdown leaves the backlight off on the next cycle
    a_shutdown_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_command == CMD_SHUTDOWN) |=> !r_bl)
        else $error("backlight still on after shutdown");

endmodule

// ----- sv/lcdn_fifo.sv -----
// ----------------------------------------------------------------------------
// lcdn_fifo
// Short job queue between the command front end and the byte sequencer.
// ----------------------------------------------------------------------------
module lcdn_fifo #(
    parameter int unsigned DEPTH = lcdn_pkg::JOB_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lcdn_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output lcdn_pkg::t_job o_job
);
    import lcdn_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("job queue overflow");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty job queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("job count did not follow a push");

endmodule

// ----- sv/lcdn_back.sv -----
// ----------------------------------------------------------------------------
// lcdn_back
// Walks the head job through its controller bytes, six expander beats per
// byte, and drives the registered result stage.
// ----------------------------------------------------------------------------
module lcdn_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  lcdn_pkg::t_job                      i_job,
    output logic                                o_pop,
    input  logic [lcdn_pkg::CFG_DATA_W-1:0]     i_pulse_wait,
    input  logic [lcdn_pkg::CFG_DATA_W-1:0]     i_command_wait,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_byte,
    output logic [lcdn_pkg::WAIT_W-1:0]         o_wait,
    output logic                                o_last,
    output logic                                o_rejected
);
    import lcdn_pkg::*;

    logic [2:0]        r_step;
    logic [2:0]        r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic [WAIT_W-1:0] r_wait;
    logic              r_last;
    logic              r_rej;

    logic              load;
    logic [7:0]        value;
    logic [3:0]        nib;
    logic              en;
    logic              final_byte;
    logic [7:0]        n_byte;
    logic [WAIT_W-1:0] n_wait;
    logic              n_last;
    logic [WAIT_W-1:0] pulse_w;
    logic [WAIT_W-1:0] cmd_w;

    assign pulse_w = {1'b0, i_pulse_wait};
    assign cmd_w   = {1'b0, i_command_wait};
    assign load    = i_job_valid && (!r_valid || i_ready);

    // Build the current expander beat from the head job
    always_comb begin
        value      = i_job.init ? init_byte(r_idx) : i_job.value;
        nib        = (r_step < 3'd3) ? value[7:4] : value[3:0];
        en         = (r_step == 3'd1) || (r_step == 3'd4);
        final_byte = !i_job.init || (r_idx == INIT_LAST);
        n_byte     = {nib, i_job.bl, en, 1'b0, i_job.rs};
        n_last     = (r_step == STEP_LAST) && final_byte;
        case (r_step)
            3'd2:    n_wait = cmd_w;
            3'd5:    n_wait = (final_byte && i_job.clr) ? cmd_w + cmd_w : cmd_w;
            default: n_wait = pulse_w;
        endcase
        if (i_job.rejected) begin
            n_byte = 8'h00;
            n_wait = '0;
            n_last = 1'b1;
        end
    end

    assign o_pop = load && n_last;

    // Advance through nibble steps and init bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                if (n_last) begin
                    r_step <= '0;
                    r_idx  <= '0;
                end else if (r_step == STEP_LAST) begin
                    r_step <= '0;
                    r_idx  <= r_idx + 1'b1;
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_wait <= n_wait;
            r_last <= n_last;
            r_rej  <= i_job.rejected;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_wait     = r_wait;
    assign o_last     = r_last;
    assign o_rejected = r_rej;

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_LAST && r_idx <= INIT_LAST)
        else $error("sequencer counters out of range");

    a_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != 3'd0 || r_idx != 3'd0) |-> i_job_valid)
        else $error("job left the queue mid sequence");

    a_rej_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_rej) |-> (r_last && r_byte == 8'h00 && r_wait == '0))
        else $error("malformed rejected result");

    a_enable_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !i_job.rejected && (r_step == 3'd1 || r_step == 3'd4)) |=> r_byte[2])
        else $error("enable missing on strobe beat");

endmodule

// ----- sv/char_lcd_i2c_nibble_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_i2c_nibble_sequencer
// The command beat is written into the job queue and the first result beat is
// then registered from its head. Throughput: one result beat per cycle while
// m_axis_tready is high; 6 beats per command, 36 for init, 1 for a rejected
// cursor position, none for unused codes, paced by the single output register.
// Reset (synchronous, active low): queue empty, backlight on, waits 1 and 4.
// ----------------------------------------------------------------------------
module char_lcd_i2c_nibble_sequencer #(
    parameter int unsigned FIFO_DEPTH = lcdn_pkg::JOB_FIFO_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [lcdn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lcdn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // command beats
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // command[2:0], char_code[10:3], column[16:11], row[18:17],
    // light_request[19], cursor_request[20], blink_request[21], zero[23:22]
    input  logic [lcdn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // result beats
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // expander_byte[7:0], wait_ms[12:8], zero[15:13]
    output logic [lcdn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    // rejected[0]
    output logic                                m_axis_tuser
);
    import lcdn_pkg::*;

    logic [CFG_DATA_W-1:0] r_pulse_wait;
    logic [CFG_DATA_W-1:0] r_command_wait;
    logic                  full;
    logic                  push;
    logic                  pop;
    logic                  job_valid;
    t_job                  push_job;
    t_job                  head_job;
    logic [7:0]            out_byte;
    logic [WAIT_W-1:0]     out_wait;

    // Capture configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_wait   <= PULSE_WAIT_RST;
            r_command_wait <= COMMAND_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PULSE_WAIT:   r_pulse_wait   <= i_cfg_data;
                CFG_COMMAND_WAIT: r_command_wait <= i_cfg_data;
                default:          r_pulse_wait   <= r_pulse_wait;
            endcase
        end
    end

    lcdn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_command   (s_axis_tdata[2:0]),
        .i_char_code (s_axis_tdata[10:3]),
        .i_column    (s_axis_tdata[16:11]),
        .i_row       (s_axis_tdata[18:17]),
        .i_light     (s_axis_tdata[19]),
        .i_cursor    (s_axis_tdata[20]),
        .i_blink     (s_axis_tdata[21]),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    lcdn_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    lcdn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (job_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .i_pulse_wait   (r_pulse_wait),
        .i_command_wait (r_command_wait),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_byte         (out_byte),
        .o_wait         (out_wait),
        .o_last         (m_axis_tlast),
        .o_rejected     (m_axis_tuser)
    );

    assign m_axis_tdata = {3'b000, out_wait, out_byte};

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the character LCD nibble sequencer. Command beats
// go in on the slave stream and expander beats are checked on the master
// stream against an in-bench model of the command expansion, the backlight
// state and the two wait registers. Wait settings change between phases
// while the block is idle. Both stream sides idle at random except in the
// final phase.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lcdn_pkg::*;

    // Codes the block must ignore
    localparam logic [2:0] CMD_UNUSED_A = 3'd6;
    localparam logic [2:0] CMD_UNUSED_B = 3'd7;

    // Expander pin bits
    localparam logic [7:0] EXP_RS = 8'h01;
    localparam logic [7:0] EXP_EN = 8'h04;
    localparam logic [7:0] EXP_BL = 8'h08;

    // Init run, first controller byte in the lowest bits
    localparam logic [47:0] INIT_BYTES = {LCD_CLEAR, LCD_CURSOR_ROW0, 8'h06,
                                          LCD_DISP_ON, 8'h28, 8'h02};

    // Cycles to let pass after the last result before a register write
    localparam int QUIET_CYCLES = 10;

    // Declared last field first so that command lands in the lowest bits
    typedef struct packed {
        logic       blink;
        logic       cursor;
        logic       light;
        logic [1:0] row;
        logic [5:0] column;
        logic [7:0] char_code;
        logic [2:0] command;
    } t_lcd_cmd;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [4:0] wait_ms;
        logic       last;
        logic       rejected;
    } t_lcd_beat;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    m_axis_tuser;

    char_lcd_i2c_nibble_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Model state: backlight and the two wait registers
    logic       backlight_q  = 1'b1;
    logic [3:0] pulse_wait   = PULSE_WAIT_RST;
    logic [3:0] command_wait = COMMAND_WAIT_RST;

    t_lcd_cmd  pending_cmds[$];
    t_lcd_beat expected_beats[$];
    t_lcd_cmd  presented_cmd;
    t_lcd_beat head_beat;

    int  queued_total   = 0;
    int  accepted_total = 0;
    int  errors         = 0;
    int  send_gap       = 0;
    int  recv_stall     = 0;
    bit  idle_en        = 1'b1;

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #8_000_000;
        $display("FAIL char_lcd_i2c_nibble_sequencer");
        $finish;
    end

    function automatic void push_beat(input logic [7:0] b, input logic [4:0] w,
                                      input logic l, input logic r);
        t_lcd_beat e;
        e.expander_byte = b;
        e.wait_ms       = w;
        e.last          = l;
        e.rejected      = r;
        expected_beats.push_back(e);
    endfunction

    // Six expander beats for one controller byte: high nibble, then low
    function automatic void push_controller_byte(input logic [7:0] value,
                                                 input logic rs, input logic fin,
                                                 input logic [4:0] extra);
        logic [7:0] base;
        logic [7:0] nib;
        logic [4:0] endw;
        base = (backlight_q ? EXP_BL : 8'h00) | (rs ? EXP_RS : 8'h00);
        for (int n = 0; n < 2; n++) begin
            nib  = ((n == 0) ? (value & 8'hF0) : {value[3:0], 4'h0}) | base;
            endw = {1'b0, command_wait} + ((n == 1 && fin) ? extra : 5'd0);
            push_beat(nib, {1'b0, pulse_wait}, 1'b0, 1'b0);
            push_beat(nib | EXP_EN, {1'b0, pulse_wait}, 1'b0, 1'b0);
            push_beat(nib, endw, (n == 1) && fin, 1'b0);
        end
    endfunction

    // Expected beats of one accepted command
    function automatic void expand_command(input t_lcd_cmd c);
        case (c.command)
            CMD_WRITE_CHAR: begin
                push_controller_byte(c.char_code, 1'b1, 1'b1, 5'd0);
            end
            CMD_SET_CURSOR: begin
                if (c.column > 6'd15 || c.row > 2'd1) begin
                    push_beat(8'h00, 5'd0, 1'b1, 1'b1);
                end else begin
                    push_controller_byte((c.row[0] ? LCD_CURSOR_ROW1 : LCD_CURSOR_ROW0)
                                         | {2'b00, c.column}, 1'b0, 1'b1, 5'd0);
                end
            end
            CMD_DISP_CTRL: begin
                backlight_q = c.light;
                push_controller_byte(LCD_DISP_ON | {6'd0, c.cursor, c.blink},
                                     1'b0, 1'b1, 5'd0);
            end
            CMD_CLEAR: begin
                push_controller_byte(LCD_CLEAR, 1'b0, 1'b1, {1'b0, command_wait});
            end
            CMD_INIT: begin
                backlight_q = 1'b1;
                for (int i = 0; i < 6; i++) begin
                    push_controller_byte(INIT_BYTES[i*8 +: 8], 1'b0, i == 5,
                                         (i == 5) ? {1'b0, command_wait} : 5'd0);
                end
            end
            CMD_SHUTDOWN: begin
                backlight_q = 1'b0;
                push_controller_byte(LCD_DISP_OFF, 1'b0, 1'b1, 5'd0);
            end
            default: begin
            end
        endcase
    endfunction

    // Driver: present pending commands, predict on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expand_command(presented_cmd);
                accepted_total++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    presented_cmd <= pending_cmds[0];
                    s_axis_tdata  <= {2'b00, pending_cmds[0]};
                    s_axis_tvalid <= 1'b1;
                    void'(pending_cmds.pop_front());
                    if (idle_en && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat: byte %h wait %0d last %b rej %b",
                             $time, m_axis_tdata[7:0], m_axis_tdata[12:8],
                             m_axis_tlast, m_axis_tuser);
                    errors++;
                end else begin
                    head_beat = expected_beats.pop_front();
                    if (m_axis_tdata[7:0] !== head_beat.expander_byte) begin
                        $display("%0t: expander_byte expected %h actual %h", $time,
                                 head_beat.expander_byte, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[12:8] !== head_beat.wait_ms) begin
                        $display("%0t: wait_ms expected %0d actual %0d", $time,
                                 head_beat.wait_ms, m_axis_tdata[12:8]);
                        errors++;
                    end
                    if (m_axis_tlast !== head_beat.last) begin
                        $display("%0t: last expected %b actual %b", $time,
                                 head_beat.last, m_axis_tlast);
                        errors++;
                    end
                    if (m_axis_tuser !== head_beat.rejected) begin
                        $display("%0t: rejected expected %b actual %b", $time,
                                 head_beat.rejected, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 5) == 0)
                    recv_stall = $urandom_range(1, 8);
            end
        end
    end

    function automatic void queue_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                                      input logic [5:0] col, input logic [1:0] row,
                                      input logic l, input logic cur, input logic b);
        t_lcd_cmd c;
        c.command   = cmd;
        c.char_code = ch;
        c.column    = col;
        c.row       = row;
        c.light     = l;
        c.cursor    = cur;
        c.blink     = b;
        pending_cmds.push_back(c);
        queued_total++;
    endfunction

    // Random commands; ignored codes are mixed in but not counted
    task automatic queue_random(input int n);
        t_lcd_cmd c;
        int       counted;
        int       pick;
        counted = 0;
        while (counted < n) begin
            c    = t_lcd_cmd'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                c.command = CMD_WRITE_CHAR;
            end else if (pick < 55) begin
                c.command = CMD_SET_CURSOR;
                // mostly legal positions, the rest anywhere in the field
                if ($urandom_range(0, 4) != 0) begin
                    c.column = 6'($urandom_range(0, 15));
                    c.row    = 2'($urandom_range(0, 1));
                end
            end else if (pick < 70) begin
                c.command = CMD_DISP_CTRL;
            end else if (pick < 78) begin
                c.command = CMD_CLEAR;
            end else if (pick < 84) begin
                c.command = CMD_INIT;
            end else if (pick < 92) begin
                c.command = CMD_SHUTDOWN;
            end else begin
                c.command = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
            end
            if (c.command != CMD_UNUSED_A && c.command != CMD_UNUSED_B)
                counted++;
            pending_cmds.push_back(c);
            queued_total++;
        end
    endtask

    // Hold until every command is taken and every result has come back
    task automatic drain();
        do @(posedge i_clk);
        while (accepted_total != queued_total || expected_beats.size() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Write both wait registers while the block is idle
    task automatic program_waits(input logic [3:0] pulse, input logic [3:0] settle);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PULSE_WAIT;
        i_cfg_data  <= pulse;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        pulse_wait   = pulse;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COMMAND_WAIT;
        i_cfg_data  <= settle;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        command_wait = settle;
    endtask

    // Main sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands with the reset wait values
        queue_cmd(CMD_WRITE_CHAR, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE_CHAR, 8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_SET_CURSOR, 8'hFF, 6'd15, 2'd1, 1'b1, 1'b1, 1'b1);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 6'd16, 2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 6'd0,  2'd2, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 6'd63, 2'd3, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_DISP_CTRL,  8'h00, 6'd0,  2'd0, 1'b0, 1'b1, 1'b1);
        queue_cmd(CMD_WRITE_CHAR, 8'h5A, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_CLEAR,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_SET_CURSOR, 8'h00, 6'd7,  2'd1, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_DISP_CTRL,  8'h00, 6'd0,  2'd0, 1'b1, 1'b0, 1'b0);
        queue_cmd(CMD_DISP_CTRL,  8'h00, 6'd0,  2'd0, 1'b1, 1'b1, 1'b0);
        queue_cmd(CMD_SHUTDOWN,   8'h00, 6'd0,  2'd0, 1'b1, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE_CHAR, 8'hA5, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_UNUSED_A,   8'hFF, 6'd63, 2'd3, 1'b1, 1'b1, 1'b1);
        queue_cmd(CMD_UNUSED_B,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_INIT,       8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_WRITE_CHAR, 8'h41, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_CLEAR,      8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        queue_cmd(CMD_SHUTDOWN,   8'h00, 6'd0,  2'd0, 1'b0, 1'b0, 1'b0);
        drain();

        // Random phases over extreme and random wait settings
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       program_waits(4'd0, 4'd0);
                1:       program_waits(4'd15, 4'd15);
                2:       program_waits(4'd15, 4'd0);
                3:       program_waits(4'd0, 4'd15);
                default: program_waits(4'($urandom_range(0, 15)),
                                       4'($urandom_range(0, 15)));
            endcase
            if (p == 5)
                idle_en = 1'b0;
            queue_random(46);
            drain();
        end

        if (expected_beats.size() != 0)
            errors++;
        if (errors == 0) begin
            $display("PASS char_lcd_i2c_nibble_sequencer");
        end else begin
            $display("FAIL char_lcd_i2c_nibble_sequencer");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lcdn_pkg.sv
sv/lcdn_front.sv
sv/lcdn_fifo.sv
sv/lcdn_back.sv
sv/char_lcd_i2c_nibble_sequencer.sv
sim/testbench.sv
